// ===== hdl/qrs_pkg.sv =====
// Shared constants for the quadratic root solver: field widths, class codes, defaults.
package qrs_pkg;

  // Parameter defaults
  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Fixed result field widths
  localparam int OUT_W   = 34;
  localparam int CLS_W   = 3;
  localparam int OUT_TW  = ((3 * OUT_W + 7) / 8) * 8;

  // Root class codes
  localparam logic [CLS_W-1:0] CLS_ANY     = 3'd0;
  localparam logic [CLS_W-1:0] CLS_NONE    = 3'd1;
  localparam logic [CLS_W-1:0] CLS_LINEAR  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_COMPLEX = 3'd3;
  localparam logic [CLS_W-1:0] CLS_DOUBLE  = 3'd4;
  localparam logic [CLS_W-1:0] CLS_TWO     = 3'd5;

endpackage

// ===== hdl/quadratic_root_solver_core.sv =====
// Pipelined quadratic root solver: discriminant, digit-serial square root and division stages.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_tvalid/in_tready  | in_tdata: coef_a, coef_b, coef_c
//  out     | out | out_tvalid/out_tready| out_tuser: root_class; out_tdata: root_one,
//          |     |                      |   root_two, discriminant
//
// One word enters per cycle while the output is not stalled. Besides the capture, product,
// discriminant, numerator and output stages there are (COEF_WIDTH+FRAC_BITS+1) square root
// stages and (COEF_WIDTH+FRAC_BITS+1) divider stages; each resolves one result bit per stage.
// Reset (rst_n low, synchronous) clears the valid bits of every stage.
// A stalled output freezes the whole pipeline; no word is lost or repeated.
module quadratic_root_solver_core #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF,
  localparam int IN_TW = ((3 * COEF_WIDTH + 7) / 8) * 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // coef_a, coef_b, coef_c, zero pad
  input  logic [IN_TW-1:0]            in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // root_class
  output logic [qrs_pkg::CLS_W-1:0]   out_tuser,
  // root_one, root_two, discriminant, zero pad
  output logic [qrs_pkg::OUT_TW-1:0]  out_tdata
);

  localparam int CW   = COEF_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int OW   = qrs_pkg::OUT_W;
  localparam int DSW  = 2 * CW + 2;      // signed discriminant
  localparam int VW   = 2 * CW + 2;      // magnitude of discriminant, padded to pairs
  localparam int SP   = CW + 1 + F;      // square root digits
  localparam int SW   = SP;              // root width
  localparam int RW   = SW + 3;          // square root remainder
  localparam int NSW  = CW + F + 2;      // signed numerator
  localparam int NW   = CW + F + 1;      // numerator magnitude and quotient
  localparam int DVW  = CW + 1;          // divisor magnitude

  typedef struct packed {
    logic [qrs_pkg::CLS_W-1:0] cls;
    logic signed [DSW-1:0]     d;
    logic signed [NSW-1:0]     nb;
    logic signed [NSW-1:0]     lin;
    logic signed [CW:0]        den;
  } smeta_t;

  typedef struct packed {
    logic [qrs_pkg::CLS_W-1:0] cls;
    logic signed [DSW-1:0]     d;
    logic                      neg1;
    logic                      neg2;
  } dmeta_t;

  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // Stage 1: capture coefficients
  logic                 s1_vld_r;
  logic signed [CW-1:0] s1_a_r, s1_b_r, s1_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r <= in_tdata[CW-1:0];
      s1_b_r <= in_tdata[2*CW-1:CW];
      s1_c_r <= in_tdata[3*CW-1:2*CW];
    end
  end

  // Stage 2: products
  logic                   s2_vld_r;
  logic signed [CW-1:0]   s2_a_r, s2_b_r, s2_c_r;
  logic signed [2*CW-1:0] s2_bb_r, s2_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_a_r  <= s1_a_r;
      s2_b_r  <= s1_b_r;
      s2_c_r  <= s1_c_r;
      s2_bb_r <= s1_b_r * s1_b_r;
      s2_ac_r <= s1_a_r * s1_c_r;
    end
  end

  // Stage 3: discriminant, class, numerators and divisor
  logic                  s3_vld_r;
  smeta_t                s3_meta_r, s3_meta_nxt;
  logic [VW-1:0]         s3_v_r, s3_v_nxt;
  logic signed [DSW-1:0] s3_d;
  logic                  a_zero, b_zero, c_zero;

  always_comb begin
    s3_d   = DSW'(s2_bb_r) - (DSW'(s2_ac_r) <<< 2);
    a_zero = (s2_a_r == '0);
    b_zero = (s2_b_r == '0);
    c_zero = (s2_c_r == '0);
    s3_meta_nxt.nb  = -(NSW'(s2_b_r) <<< F);
    s3_meta_nxt.lin = -(NSW'(s2_c_r) <<< F);
    s3_meta_nxt.d   = a_zero ? '0 : s3_d;
    s3_v_nxt        = VW'(s3_meta_nxt.d[DSW-1] ? -s3_meta_nxt.d : s3_meta_nxt.d);
    if (a_zero && b_zero && c_zero) begin
      s3_meta_nxt.cls = qrs_pkg::CLS_ANY;
    end else if (a_zero && b_zero) begin
      s3_meta_nxt.cls = qrs_pkg::CLS_NONE;
    end else if (a_zero) begin
      s3_meta_nxt.cls = qrs_pkg::CLS_LINEAR;
    end else if (s3_d[DSW-1]) begin
      s3_meta_nxt.cls = qrs_pkg::CLS_COMPLEX;
    end else if (s3_d == '0) begin
      s3_meta_nxt.cls = qrs_pkg::CLS_DOUBLE;
    end else begin
      s3_meta_nxt.cls = qrs_pkg::CLS_TWO;
    end
    if (!a_zero) begin
      s3_meta_nxt.den = (CW+1)'(s2_a_r) <<< 1;
    end else if (!b_zero) begin
      s3_meta_nxt.den = (CW+1)'(s2_b_r);
    end else begin
      s3_meta_nxt.den = (CW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_meta_r <= s3_meta_nxt;
      s3_v_r    <= s3_v_nxt;
    end
  end

  // Square root: one digit per stage
  logic          sq_vld_r  [SP];
  smeta_t        sq_meta_r [SP];
  logic [VW-1:0] sq_v_r    [SP];
  logic [SW-1:0] sq_root_r [SP];
  logic [RW-1:0] sq_rem_r  [SP];

  for (genvar k = 0; k < SP; k++) begin : g_sqrt
    localparam int I = SP - 1 - k;
    logic          vld_in;
    smeta_t        meta_in;
    logic [VW-1:0] v_in;
    logic [SW-1:0] root_in, root_nxt;
    logic [RW-1:0] rem_in, rem_n, trial, rem_nxt;
    logic [1:0]    pair;
    logic          ge;

    if (k == 0) begin : g_first
      assign vld_in  = s3_vld_r;
      assign meta_in = s3_meta_r;
      assign v_in    = s3_v_r;
      assign root_in = '0;
      assign rem_in  = '0;
    end else begin : g_next
      assign vld_in  = sq_vld_r[k-1];
      assign meta_in = sq_meta_r[k-1];
      assign v_in    = sq_v_r[k-1];
      assign root_in = sq_root_r[k-1];
      assign rem_in  = sq_rem_r[k-1];
    end

    if (I >= F) begin : g_pair
      assign pair = v_in[2*(I-F)+1 : 2*(I-F)];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    always_comb begin
      rem_n    = {rem_in[RW-3:0], pair};
      trial    = RW'({root_in, 2'b01});
      ge       = (rem_n >= trial);
      rem_nxt  = ge ? (rem_n - trial) : rem_n;
      root_nxt = {root_in[SW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else if (en) begin
        sq_vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_meta_r[k] <= meta_in;
        sq_v_r[k]    <= v_in;
        sq_root_r[k] <= root_nxt;
        sq_rem_r[k]  <= rem_nxt;
      end
    end
  end

  // Stage 4: pick numerators per class, split into sign and magnitude
  logic                  s4_vld_r;
  dmeta_t                s4_meta_r, s4_meta_nxt;
  logic [NW-1:0]         s4_n1_r, s4_n2_r, s4_n1_nxt, s4_n2_nxt;
  logic [DVW-1:0]        s4_dv_r, s4_dv_nxt;
  smeta_t                sm;
  logic signed [NSW-1:0] sv, n1, n2;

  always_comb begin
    sm = sq_meta_r[SP-1];
    sv = NSW'(sq_root_r[SP-1]);
    case (sm.cls)
      qrs_pkg::CLS_LINEAR: begin
        n1 = sm.lin;
        n2 = '0;
      end
      qrs_pkg::CLS_COMPLEX: begin
        n1 = sm.nb;
        n2 = sv;
      end
      qrs_pkg::CLS_DOUBLE: begin
        n1 = sm.nb;
        n2 = '0;
      end
      qrs_pkg::CLS_TWO: begin
        n1 = sm.nb + sv;
        n2 = sm.nb - sv;
      end
      default: begin
        n1 = '0;
        n2 = '0;
      end
    endcase
    s4_n1_nxt        = NW'(n1[NSW-1] ? -n1 : n1);
    s4_n2_nxt        = NW'(n2[NSW-1] ? -n2 : n2);
    s4_dv_nxt        = DVW'(sm.den[CW] ? -sm.den : sm.den);
    s4_meta_nxt.cls  = sm.cls;
    s4_meta_nxt.d    = sm.d;
    s4_meta_nxt.neg1 = n1[NSW-1] ^ sm.den[CW];
    s4_meta_nxt.neg2 = n2[NSW-1] ^ sm.den[CW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= sq_vld_r[SP-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_meta_r <= s4_meta_nxt;
      s4_n1_r   <= s4_n1_nxt;
      s4_n2_r   <= s4_n2_nxt;
      s4_dv_r   <= s4_dv_nxt;
    end
  end

  // Division: one quotient bit per stage for both dividends
  logic           dv_vld_r  [NW];
  dmeta_t         dv_meta_r [NW];
  logic [DVW-1:0] dv_dv_r   [NW];
  logic [NW-1:0]  dv_n1_r   [NW];
  logic [NW-1:0]  dv_n2_r   [NW];
  logic [NW-1:0]  dv_q1_r   [NW];
  logic [NW-1:0]  dv_q2_r   [NW];
  logic [DVW-1:0] dv_r1_r   [NW];
  logic [DVW-1:0] dv_r2_r   [NW];

  for (genvar j = 0; j < NW; j++) begin : g_div
    localparam int BI = NW - 1 - j;
    logic           vld_in;
    dmeta_t         meta_in;
    logic [DVW-1:0] dv_in, r1_in, r2_in, r1_nxt, r2_nxt;
    logic [NW-1:0]  n1_in, n2_in, q1_in, q2_in, q1_nxt, q2_nxt;
    logic [DVW:0]   r1_n, r2_n, r1_d, r2_d;
    logic           ge1, ge2;

    if (j == 0) begin : g_first
      assign vld_in  = s4_vld_r;
      assign meta_in = s4_meta_r;
      assign dv_in   = s4_dv_r;
      assign n1_in   = s4_n1_r;
      assign n2_in   = s4_n2_r;
      assign q1_in   = '0;
      assign q2_in   = '0;
      assign r1_in   = '0;
      assign r2_in   = '0;
    end else begin : g_next
      assign vld_in  = dv_vld_r[j-1];
      assign meta_in = dv_meta_r[j-1];
      assign dv_in   = dv_dv_r[j-1];
      assign n1_in   = dv_n1_r[j-1];
      assign n2_in   = dv_n2_r[j-1];
      assign q1_in   = dv_q1_r[j-1];
      assign q2_in   = dv_q2_r[j-1];
      assign r1_in   = dv_r1_r[j-1];
      assign r2_in   = dv_r2_r[j-1];
    end

    always_comb begin
      r1_n   = {r1_in, n1_in[BI]};
      r2_n   = {r2_in, n2_in[BI]};
      ge1    = (r1_n >= {1'b0, dv_in});
      ge2    = (r2_n >= {1'b0, dv_in});
      r1_d   = r1_n - {1'b0, dv_in};
      r2_d   = r2_n - {1'b0, dv_in};
      r1_nxt = ge1 ? r1_d[DVW-1:0] : r1_n[DVW-1:0];
      r2_nxt = ge2 ? r2_d[DVW-1:0] : r2_n[DVW-1:0];
      q1_nxt     = q1_in;
      q1_nxt[BI] = ge1;
      q2_nxt     = q2_in;
      q2_nxt[BI] = ge2;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j] <= 1'b0;
      end else if (en) begin
        dv_vld_r[j] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_meta_r[j] <= meta_in;
        dv_dv_r[j]   <= dv_in;
        dv_n1_r[j]   <= n1_in;
        dv_n2_r[j]   <= n2_in;
        dv_q1_r[j]   <= q1_nxt;
        dv_q2_r[j]   <= q2_nxt;
        dv_r1_r[j]   <= r1_nxt;
        dv_r2_r[j]   <= r2_nxt;
      end
    end
  end

  // Output stage: apply signs and fit to result widths
  logic                      out_vld_r;
  logic [qrs_pkg::CLS_W-1:0] out_cls_r;
  logic [OW-1:0]             out_r1_r, out_r2_r, out_d_r;
  logic [OW-1:0]             r1_fit, r2_fit, d_fit;
  logic signed [NW:0]        qs1, qs2;
  dmeta_t                    fm;

  always_comb begin
    fm  = dv_meta_r[NW-1];
    qs1 = fm.neg1 ? -$signed({1'b0, dv_q1_r[NW-1]}) : $signed({1'b0, dv_q1_r[NW-1]});
    qs2 = fm.neg2 ? -$signed({1'b0, dv_q2_r[NW-1]}) : $signed({1'b0, dv_q2_r[NW-1]});
  end

  if (NW + 1 >= OW) begin : g_qtrunc
    assign r1_fit = qs1[OW-1:0];
    assign r2_fit = qs2[OW-1:0];
  end else begin : g_qext
    assign r1_fit = {{(OW-NW-1){qs1[NW]}}, qs1};
    assign r2_fit = {{(OW-NW-1){qs2[NW]}}, qs2};
  end

  if (DSW >= OW) begin : g_dtrunc
    assign d_fit = fm.d[OW-1:0];
  end else begin : g_dext
    assign d_fit = {{(OW-DSW){fm.d[DSW-1]}}, fm.d};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld_r[NW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_cls_r <= fm.cls;
      out_r1_r  <= r1_fit;
      out_r2_r  <= r2_fit;
      out_d_r   <= d_fit;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_cls_r;
  assign out_tdata  = {{(qrs_pkg::OUT_TW - 3*OW){1'b0}}, out_d_r, out_r2_r, out_r1_r};

  // Checks on delivered results
  a_flat_disc : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == qrs_pkg::CLS_ANY || out_tuser == qrs_pkg::CLS_NONE ||
                   out_tuser == qrs_pkg::CLS_LINEAR) |-> out_d_r == '0)
    else $error("degenerate class with nonzero discriminant");

  a_flat_roots : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == qrs_pkg::CLS_ANY || out_tuser == qrs_pkg::CLS_NONE)
    |-> out_r1_r == '0 && out_r2_r == '0)
    else $error("no-root class with nonzero roots");

  a_double : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == qrs_pkg::CLS_DOUBLE |-> out_d_r == '0 && out_r2_r == '0)
    else $error("double root inconsistent");

  a_complex : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == qrs_pkg::CLS_COMPLEX |-> out_d_r[OW-1])
    else $error("complex class with nonnegative discriminant");

endmodule
